>>> hw/rtl/fcmi_pkg.sv
// fcmi_pkg: shared types, sizes, register indexes and the logistic table
// of the fuzzy cognitive map inference block
// no dependencies
package fcmi_pkg;

    // map size and derived widths
    localparam int NUM_CONCEPTS = 32;
    localparam int IDX_W        = $clog2(NUM_CONCEPTS);
    localparam int WADDR_W      = $clog2(NUM_CONCEPTS * NUM_CONCEPTS);
    localparam int REPORT_COUNT = (NUM_CONCEPTS < 32) ? NUM_CONCEPTS : 32;

    // logistic table: SIG_SIZE intervals over -8 .. +8
    localparam int SIG_LOG  = 8;
    localparam int SIG_SIZE = 1 << SIG_LOG;
    localparam int Z_FRAC   = 20;   // interpolation position fraction bits

    // arithmetic widths
    localparam int ACC_W    = 32 + IDX_W + 1;  // exact weighted sum
    localparam int ACC_LO_W = 19;              // low part for split gain product
    localparam int ACC_HI_W = ACC_W - ACC_LO_W;
    localparam int SUM_W    = 24;              // change sum

    // input field widths
    localparam int FUNC_W = 2;
    localparam int FIELD_IDX_W = 5;
    localparam int DATA_W = 16;

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_WR_WEIGHT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_CONCEPT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN        = 2'd2;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROUNDS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WATCH_RND = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WATCH_CON = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic             load_weight;
        logic             load_concept;
        logic             issue;        // start one multiply-accumulate
        logic [IDX_W-1:0] j;            // source concept
        logic [IDX_W-1:0] i;            // target concept
        logic             mul_lo;
        logic             mul_hi;
        logic             zcalc;
        logic             interp;
        logic             wrback;
        logic             watched;
        logic             clr_sum;
        logic             flip;
        logic             out_rd;
        logic             out_load;
        logic [IDX_W-1:0] k;            // concept being reported
        logic             last;
    } fcmi_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic mac_busy;
    } fcmi_stat_t;

    typedef logic [15:0] sig_tab_t [0:SIG_SIZE];

    // restoring shift and subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned q, r;
        begin
            q = 0;
            r = 0;
            for (int bit_n = 63; bit_n >= 0; bit_n--) begin
                r = {r[62:0], a[bit_n]};
                if (r >= b) begin
                    r = r - b;
                    q[bit_n] = 1'b1;
                end
            end
            return q;
        end
    endfunction

    // one table entry, integer series for e^-x squared four times
    function automatic logic [15:0] sig_entry(input int k);
        longint          num;
        longint unsigned mag, s16, term, pos, neg, e, den, v, one;
        longint unsigned n;
        begin
            one  = 64'd1 << 31;
            num  = 16 * longint'(k) - 8 * longint'(SIG_SIZE);
            mag  = (num < 0) ? longint'(-num) : longint'(num);
            s16  = (mag << 31) >> (4 + SIG_LOG);
            term = one;
            pos  = one;
            neg  = 0;
            for (n = 1; n <= 14; n++) begin
                term = udiv64((term * s16) >> 31, n);
                if (n[0]) neg = neg + term;
                else pos = pos + term;
            end
            e = pos - neg;
            for (n = 0; n < 4; n++) e = (e * e) >> 31;
            den = one + e;
            if (num >= 0) v = udiv64((64'd1 << 47) + (den >> 1), den);
            else v = udiv64((e << 16) + (den >> 1), den);
            if (v > 64'd65535) v = 64'd65535;
            return v[15:0];
        end
    endfunction

    function automatic sig_tab_t build_sig_tab();
        sig_tab_t t;
        begin
            for (int k = 0; k <= SIG_SIZE; k++) t[k] = sig_entry(k);
            return t;
        end
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

>>> hw/rtl/fcmi_ctrl.sv
// fcmi_ctrl: sequencer for loads, inference rounds and result output
// depends on fcmi_pkg
module fcmi_ctrl
    import fcmi_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [FUNC_W-1:0]      func,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [6:0]             rounds,
    input  logic [6:0]             watch_rounds,
    output fcmi_cmd_t              cmd,
    input  fcmi_stat_t             stat
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MAC    = 4'd1;
    localparam logic [3:0] ST_DRAIN  = 4'd2;
    localparam logic [3:0] ST_MULLO  = 4'd3;
    localparam logic [3:0] ST_MULHI  = 4'd4;
    localparam logic [3:0] ST_ZCALC  = 4'd5;
    localparam logic [3:0] ST_INTERP = 4'd6;
    localparam logic [3:0] ST_WRBACK = 4'd7;
    localparam logic [3:0] ST_OUTRD  = 4'd8;
    localparam logic [3:0] ST_OUTLD  = 4'd9;
    localparam logic [3:0] ST_OUTW   = 4'd10;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CONCEPTS - 1);
    localparam logic [IDX_W-1:0] K_LAST   = IDX_W'(REPORT_COUNT - 1);

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [6:0]       r_reg, r_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUTW);
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        cmd        = '0;
        cmd.j      = j_reg;
        cmd.i      = i_reg;
        cmd.k      = k_reg;
        cmd.last   = (k_reg == K_LAST);
        cmd.watched = ({1'b0, r_reg} + {1'b0, watch_rounds}) >= {1'b0, rounds};
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_weight  = (func == FUNC_WR_WEIGHT);
                    cmd.load_concept = (func == FUNC_WR_CONCEPT);
                    if (func == FUNC_RUN) begin
                        cmd.clr_sum = 1'b1;
                        i_next = '0;
                        j_next = '0;
                        k_next = '0;
                        r_next = '0;
                        state_next = (rounds == 7'd0) ? ST_OUTRD : ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
                j_next = j_reg + 1'b1;
                if (j_reg == IDX_LAST) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!stat.mac_busy) state_next = ST_MULLO;
            end
            ST_MULLO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MULHI;
            end
            ST_MULHI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ZCALC;
            end
            ST_ZCALC: begin
                cmd.zcalc = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.interp = 1'b1;
                state_next = ST_WRBACK;
            end
            ST_WRBACK: begin
                cmd.wrback = 1'b1;
                j_next = '0;
                if (i_reg == IDX_LAST) begin
                    cmd.flip = 1'b1;
                    i_next = '0;
                    r_next = r_reg + 1'b1;
                    state_next = (r_reg + 1'b1 == rounds) ? ST_OUTRD : ST_MAC;
                end else begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_OUTRD: begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUTLD;
            end
            ST_OUTLD: begin
                cmd.out_load = 1'b1;
                state_next = ST_OUTW;
            end
            ST_OUTW: begin
                if (m_tready) begin
                    if (k_reg == K_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + 1'b1;
                        state_next = ST_OUTRD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
        end
    end

endmodule

>>> hw/rtl/fcmi_dpath.sv
// fcmi_dpath: weight memory, concept banks, multiply-accumulate, logistic
// and change sum; output word register
// depends on fcmi_pkg
module fcmi_dpath
    import fcmi_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fcmi_cmd_t              cmd,
    output fcmi_stat_t             stat,
    input  logic [FIELD_IDX_W-1:0] row_index,
    input  logic [FIELD_IDX_W-1:0] col_index,
    input  logic [DATA_W-1:0]      data_value,
    input  logic [15:0]            gain,
    input  logic [5:0]             watch_concepts,
    input  logic [15:0]            tolerance,
    output logic [IDX_W-1:0]       out_index,
    output logic [15:0]            out_value,
    output logic                   out_conv,
    output logic                   out_last
);

    localparam int Z_W    = ACC_W + 17 - 26;   // floored logistic argument
    localparam int FRAC_H = Z_FRAC - SIG_LOG;  // low bits of position left after index
    localparam int WC_W   = IDX_W + 1;

    // weight memory
    logic [DATA_W-1:0]  wmem [0:NUM_CONCEPTS*NUM_CONCEPTS-1];
    logic [DATA_W-1:0]  w_rd_reg;
    logic [WADDR_W-1:0] w_wr_addr, w_rd_addr;
    logic               row_ok, col_ok;

    assign row_ok    = ({1'b0, row_index} < (FIELD_IDX_W+1)'(NUM_CONCEPTS));
    assign col_ok    = ({1'b0, col_index} < (FIELD_IDX_W+1)'(NUM_CONCEPTS));
    assign w_wr_addr = {row_index[IDX_W-1:0], col_index[IDX_W-1:0]};
    assign w_rd_addr = {cmd.j, cmd.i};

    always_ff @(posedge aclk) begin
        if (cmd.load_weight && row_ok && col_ok) wmem[w_wr_addr] <= data_value;
        w_rd_reg <= wmem[w_rd_addr];
    end

    // concept banks: current in bank sel, next round written into the other
    logic [15:0]      bank0_reg [0:NUM_CONCEPTS-1];
    logic [15:0]      bank1_reg [0:NUM_CONCEPTS-1];
    logic             sel_reg;
    logic [15:0]      c_rd_reg;
    logic [IDX_W-1:0] c_rd_addr;
    logic [15:0]      new_val;

    assign c_rd_addr = cmd.out_rd ? cmd.k : cmd.j;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
            for (int n = 0; n < NUM_CONCEPTS; n++) begin
                bank0_reg[n] <= '0;
                bank1_reg[n] <= '0;
            end
        end else begin
            if (cmd.load_concept && row_ok) begin
                if (sel_reg) bank1_reg[row_index[IDX_W-1:0]] <= data_value;
                else bank0_reg[row_index[IDX_W-1:0]] <= data_value;
            end
            if (cmd.wrback) begin
                if (sel_reg) bank0_reg[cmd.i] <= new_val;
                else bank1_reg[cmd.i] <= new_val;
            end
            if (cmd.flip) sel_reg <= !sel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        c_rd_reg <= sel_reg ? bank1_reg[c_rd_addr] : bank0_reg[c_rd_addr];
    end

    // multiply-accumulate pipeline
    logic                    s1_v_reg, s2_v_reg;
    logic [IDX_W-1:0]        s1_j_reg;
    logic signed [33:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [15:0]             old_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_j_reg <= cmd.j;
        if (s1_v_reg) begin
            prod_reg <= 34'(signed'({1'b0, c_rd_reg}) * signed'(w_rd_reg));
            if (s1_j_reg == cmd.i) old_reg <= c_rd_reg;
        end
        if (cmd.issue && cmd.j == '0) acc_reg <= '0;
        else if (s2_v_reg) acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    assign stat.mac_busy = s1_v_reg || s2_v_reg;

    // gain product in two halves, then floored argument and table position
    logic [ACC_LO_W+15:0]        plo_reg;
    logic signed [ACC_HI_W+16:0] phi_reg;
    logic signed [ACC_W+16:0]    gprod;
    logic signed [Z_W-1:0]       zq;
    logic                        sat_lo_reg, sat_hi_reg;
    logic [Z_FRAC-1:0]           u_reg;

    assign gprod = (ACC_W+17)'(phi_reg) * (ACC_W+17)'(2 ** ACC_LO_W)
                 + signed'((ACC_W+17)'(plo_reg));
    assign zq    = gprod[ACC_W+16:26];

    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) plo_reg <= acc_reg[ACC_LO_W-1:0] * gain;
        if (cmd.mul_hi)
            phi_reg <= signed'(acc_reg[ACC_W-1:ACC_LO_W]) * signed'({1'b0, gain});
        if (cmd.zcalc) begin
            sat_lo_reg <= (zq <= -signed'(Z_W'(2 ** (Z_FRAC-1))));
            sat_hi_reg <= (zq >= signed'(Z_W'(2 ** (Z_FRAC-1))));
            u_reg      <= {~zq[Z_FRAC-1], zq[Z_FRAC-2:0]};
        end
    end

    // table lookup and interpolation
    logic [SIG_LOG-1:0]   idx;
    logic [Z_FRAC-1:0]    frac;
    logic [15:0]          lo_val, hi_val;
    logic [15:0]          lo_reg;
    logic [Z_FRAC+15:0]   ip_reg;
    logic [Z_FRAC+15:0]   ip_rnd;

    assign idx    = u_reg[Z_FRAC-1:FRAC_H];
    assign frac   = {u_reg[FRAC_H-1:0], {SIG_LOG{1'b0}}};
    assign lo_val = SIG_TAB[idx];
    assign hi_val = SIG_TAB[{1'b0, idx} + 1'b1];

    always_ff @(posedge aclk) begin
        if (cmd.interp) begin
            lo_reg <= sat_lo_reg ? SIG_TAB[0] : (sat_hi_reg ? SIG_TAB[SIG_SIZE] : lo_val);
            ip_reg <= (sat_lo_reg || sat_hi_reg) ? '0 : (hi_val - lo_val) * frac;
        end
    end

    assign ip_rnd  = ip_reg + (Z_FRAC+16)'(2 ** (Z_FRAC-1));
    assign new_val = lo_reg + ip_rnd[Z_FRAC+15:Z_FRAC];

    // change sum over the watched concepts
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W:0]   sum_add;
    logic [15:0]      delta;
    logic [WC_W-1:0]  wc;
    logic             in_watch;

    assign wc       = ({1'b0, watch_concepts} > 7'(NUM_CONCEPTS))
                    ? WC_W'(NUM_CONCEPTS) : WC_W'(watch_concepts);
    assign in_watch = ({1'b0, cmd.i} + wc) >= WC_W'(NUM_CONCEPTS);
    assign delta    = (new_val > old_reg) ? new_val - old_reg : old_reg - new_val;
    assign sum_add  = {1'b0, sum_reg} + (SUM_W+1)'(delta);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cmd.clr_sum) begin
            sum_reg <= '0;
        end else if (cmd.wrback && cmd.watched && in_watch) begin
            sum_reg <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_index <= cmd.k;
            out_value <= c_rd_reg;
            out_conv  <= (sum_reg < SUM_W'(tolerance));
            out_last  <= cmd.last;
        end
    end

endmodule

>>> hw/rtl/fuzzy_cognitive_map_inference.sv
// fuzzy_cognitive_map_inference: top level, configuration registers,
// controller and datapath; depends on fcmi_pkg, fcmi_ctrl, fcmi_dpath
//
// Input words load the map: tuser selects writing weight W[row][col]
// (signed Q2.14), writing initial concept[row] (0.16) or starting a run.
// Load words are accepted one per cycle while idle. A run performs `rounds`
// inference rounds; each target concept takes a multiply-accumulate over all
// NUM_CONCEPTS sources (one weight memory read per cycle) followed by drain,
// gain product, table lookup and writeback. Then one output word per
// concept follows, carrying index, value, the convergence flag (tuser)
// and tlast on the final one. While a word waits, the block holds it and
// stalls; no input is taken until the last word is delivered.
// Reset clears the configuration to defaults and both concept banks to zero;
// weights are undefined until written. The configuration port writes one
// register per cycle and is to be used only while the block is idle; the
// block itself does not enforce this.
module fuzzy_cognitive_map_inference
    import fcmi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // row_index, col_index, data_value
    input  logic [1:0]            s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // concept_index, concept_value
    output logic                  m_tuser,   // converged
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0]           cfg_wdata
);

    logic [15:0] gain_reg, tol_reg;
    logic [6:0]  rounds_reg, wrnd_reg;
    logic [5:0]  wcon_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= 16'd40960;
            rounds_reg <= 7'd21;
            wrnd_reg   <= 7'd6;
            wcon_reg   <= 6'd2;
            tol_reg    <= 16'd6554;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_GAIN:      gain_reg   <= cfg_wdata;
                CFG_ROUNDS:    rounds_reg <= cfg_wdata[6:0];
                CFG_WATCH_RND: wrnd_reg   <= cfg_wdata[6:0];
                CFG_WATCH_CON: wcon_reg   <= cfg_wdata[5:0];
                CFG_TOLERANCE: tol_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fcmi_cmd_t        cmd;
    fcmi_stat_t       stat;
    logic [IDX_W-1:0] out_index;
    logic [15:0]      out_value;

    fcmi_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .func         (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .rounds       (rounds_reg),
        .watch_rounds (wrnd_reg),
        .cmd          (cmd),
        .stat         (stat)
    );

    fcmi_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .row_index      (s_tdata[4:0]),
        .col_index      (s_tdata[9:5]),
        .data_value     (s_tdata[25:10]),
        .gain           (gain_reg),
        .watch_concepts (wcon_reg),
        .tolerance      (tol_reg),
        .out_index      (out_index),
        .out_value      (out_value),
        .out_conv       (m_tuser),
        .out_last       (m_tlast)
    );

    assign m_tdata = {3'b000, out_value, 5'(out_index)};

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while an output word is pending");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("block not idle after last word");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == FUNC_RUN) |=> !s_tready)
        else $error("run command did not start the sequencer");

endmodule
